// File: rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int RES_MAX = 4;

    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_QUOTE = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_CTRL       = 4'd1,
        ERR_ESCAPE     = 4'd2,
        ERR_CUT_ESCAPE = 4'd3,
        ERR_NON_HEX    = 4'd4,
        ERR_CUT_HEX    = 4'd5,
        ERR_LONE_HIGH  = 4'd6,
        ERR_BAD_LOW    = 4'd7,
        ERR_LONE_LOW   = 4'd8,
        ERR_BAD_LEAD   = 4'd9,
        ERR_CUT_UTF8   = 4'd10,
        ERR_BAD_CONT   = 4'd11,
        ERR_NON_CANON  = 4'd12,
        ERR_UNTERM     = 4'd13
    } t_err;

    // Results of one item: cnt results, data[0] goes out first.
    typedef struct packed {
        logic [2:0]                 cnt;
        logic [RES_MAX-1:0][7:0]    data;
        t_status                    status;
        t_err                       err;
    } t_bundle;

endpackage

// File: rtl/core/jsu_in_if.sv
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_start;
    logic       text_ended;

    modport source (output valid, output text_byte, output string_start,
                    output text_ended, input ready);
    modport sink   (input valid, input text_byte, input string_start,
                    input text_ended, output ready);
endinterface

// File: rtl/core/jsu_out_if.sv
`timescale 1ns / 1ps

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic [1:0] status;
    logic [3:0] err_code;
    logic       last;

    modport source (output valid, output decoded_byte, output status,
                    output err_code, output last, input ready);
    modport sink   (input valid, input decoded_byte, input status,
                    input err_code, input last, output ready);
endinterface

// File: rtl/core/jsu_decode.sv
`timescale 1ns / 1ps

module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_text_byte,
    input  logic             i_string_start,
    input  logic             i_text_ended,
    output jsu_pkg::t_bundle o_bundle
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [20:0] HI_MIN   = 21'h00d800;
    localparam logic [20:0] HI_MAX   = 21'h00dbff;
    localparam logic [20:0] LO_MIN   = 21'h00dc00;
    localparam logic [20:0] LO_MAX   = 21'h00dfff;
    localparam logic [20:0] CP_MAX   = 21'h10ffff;
    localparam logic [20:0] PLANE1   = 21'h010000;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TEXT, PH_ESC, PH_HEX_FIRST,
        PH_WANT_BS, PH_WANT_U, PH_HEX_SECOND, PH_RAW
    } t_phase;

    t_phase      r_phase, n_phase, w_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt, w_hex_cnt;
    logic [20:0] r_acc, n_acc, w_acc;
    logic [9:0]  r_high, n_high, w_high;
    logic [1:0]  r_left, n_left, w_left;
    logic [2:0]  r_len, n_len, w_len;

    logic        w_hex_ok;
    logic [3:0]  w_hex_val;
    logic [20:0] w_acc_hex;
    logic [20:0] w_acc_raw;
    logic [1:0]  w_left_dec;
    logic [20:0] w_min;
    logic [20:0] w_pair;
    logic        w_emit;
    logic [20:0] w_cp;
    t_bundle     w_res;

    function automatic t_bundle fail_res(input t_err err);
        t_bundle b;
        b        = '0;
        b.cnt    = 3'd1;
        b.status = ST_ERROR;
        b.err    = err;
        return b;
    endfunction

    function automatic t_bundle encode_cp(input logic [20:0] cp);
        t_bundle b;
        b        = '0;
        b.status = ST_BYTE;
        b.err    = ERR_NONE;
        if (cp <= 21'h7f) begin
            b.cnt     = 3'd1;
            b.data[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            b.cnt     = 3'd2;
            b.data[0] = {3'b110, cp[10:6]};
            b.data[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            b.cnt     = 3'd3;
            b.data[0] = {4'b1110, cp[15:12]};
            b.data[1] = {2'b10, cp[11:6]};
            b.data[2] = {2'b10, cp[5:0]};
        end else begin
            b.cnt     = 3'd4;
            b.data[0] = {5'b11110, cp[20:18]};
            b.data[1] = {2'b10, cp[17:12]};
            b.data[2] = {2'b10, cp[11:6]};
            b.data[3] = {2'b10, cp[5:0]};
        end
        return b;
    endfunction

    // A start clears the decoder before this item is looked at.
    always_comb begin
        if (i_string_start) begin
            w_phase   = PH_TEXT;
            w_hex_cnt = '0;
            w_acc     = '0;
            w_high    = '0;
            w_left    = '0;
            w_len     = '0;
        end else begin
            w_phase   = r_phase;
            w_hex_cnt = r_hex_cnt;
            w_acc     = r_acc;
            w_high    = r_high;
            w_left    = r_left;
            w_len     = r_len;
        end
    end

    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = i_text_byte[3:0];
        if (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) begin
            w_hex_val = i_text_byte[3:0];
        end else if ((i_text_byte >= 8'h61 && i_text_byte <= 8'h66) ||
                     (i_text_byte >= 8'h41 && i_text_byte <= 8'h46)) begin
            w_hex_val = i_text_byte[3:0] + 4'd9;
        end else begin
            w_hex_ok  = 1'b0;
        end
    end

    assign w_acc_hex  = {w_acc[16:0], w_hex_val};
    assign w_acc_raw  = {w_acc[14:0], i_text_byte[5:0]};
    assign w_left_dec = w_left - 2'd1;
    assign w_min      = (w_len == 3'd2) ? 21'h80 : (w_len == 3'd3) ? 21'h800 : PLANE1;
    assign w_pair     = PLANE1 + {1'b0, w_high, w_acc_hex[9:0]};

    always_comb begin
        n_phase   = w_phase;
        n_hex_cnt = w_hex_cnt;
        n_acc     = w_acc;
        n_high    = w_high;
        n_left    = w_left;
        n_len     = w_len;
        w_emit    = 1'b0;
        w_cp      = '0;
        w_res     = '0;
        if (w_phase != PH_IDLE) begin
            if (i_text_ended) begin
                n_phase = PH_IDLE;
                unique case (w_phase)
                    PH_ESC:                     w_res = fail_res(ERR_CUT_ESCAPE);
                    PH_HEX_FIRST, PH_HEX_SECOND: w_res = fail_res(ERR_CUT_HEX);
                    PH_WANT_BS, PH_WANT_U:      w_res = fail_res(ERR_LONE_HIGH);
                    PH_RAW:                     w_res = fail_res(ERR_CUT_UTF8);
                    PH_IDLE, PH_TEXT:           w_res = fail_res(ERR_UNTERM);
                endcase
            end else begin
                unique case (w_phase)
                    PH_ESC: begin
                        n_phase = PH_TEXT;
                        unique case (i_text_byte)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                                w_emit = 1'b1;
                                w_cp   = {13'd0, i_text_byte};
                            end
                            CH_B: begin w_emit = 1'b1; w_cp = 21'h08; end
                            CH_F: begin w_emit = 1'b1; w_cp = 21'h0c; end
                            CH_N: begin w_emit = 1'b1; w_cp = 21'h0a; end
                            CH_R: begin w_emit = 1'b1; w_cp = 21'h0d; end
                            CH_T: begin w_emit = 1'b1; w_cp = 21'h09; end
                            CH_U: begin
                                n_phase   = PH_HEX_FIRST;
                                n_hex_cnt = '0;
                                n_acc     = '0;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                w_res   = fail_res(ERR_ESCAPE);
                            end
                        endcase
                    end
                    PH_HEX_FIRST, PH_HEX_SECOND: begin
                        if (!w_hex_ok) begin
                            n_phase = PH_IDLE;
                            w_res   = fail_res(ERR_NON_HEX);
                        end else begin
                            n_acc = w_acc_hex;
                            if (w_hex_cnt == 2'd3) begin
                                n_hex_cnt = '0;
                                if (w_phase == PH_HEX_FIRST) begin
                                    if (w_acc_hex >= HI_MIN && w_acc_hex <= HI_MAX) begin
                                        n_high  = w_acc_hex[9:0];
                                        n_phase = PH_WANT_BS;
                                    end else if (w_acc_hex >= LO_MIN &&
                                                 w_acc_hex <= LO_MAX) begin
                                        n_phase = PH_IDLE;
                                        w_res   = fail_res(ERR_LONE_LOW);
                                    end else begin
                                        w_emit  = 1'b1;
                                        w_cp    = w_acc_hex;
                                        n_phase = PH_TEXT;
                                    end
                                end else if (w_acc_hex < LO_MIN || w_acc_hex > LO_MAX) begin
                                    n_phase = PH_IDLE;
                                    w_res   = fail_res(ERR_BAD_LOW);
                                end else begin
                                    w_emit  = 1'b1;
                                    w_cp    = w_pair;
                                    n_phase = PH_TEXT;
                                end
                            end else begin
                                n_hex_cnt = w_hex_cnt + 2'd1;
                            end
                        end
                    end
                    PH_WANT_BS: begin
                        if (i_text_byte == CH_BSLASH) begin
                            n_phase = PH_WANT_U;
                        end else begin
                            n_phase = PH_IDLE;
                            w_res   = fail_res(ERR_LONE_HIGH);
                        end
                    end
                    PH_WANT_U: begin
                        if (i_text_byte == CH_U) begin
                            n_phase   = PH_HEX_SECOND;
                            n_hex_cnt = '0;
                            n_acc     = '0;
                        end else begin
                            n_phase = PH_IDLE;
                            w_res   = fail_res(ERR_LONE_HIGH);
                        end
                    end
                    PH_RAW: begin
                        if (i_text_byte[7:6] != 2'b10) begin
                            n_phase = PH_IDLE;
                            w_res   = fail_res(ERR_BAD_CONT);
                        end else begin
                            n_acc  = w_acc_raw;
                            n_left = w_left_dec;
                            if (w_left_dec == 2'd0) begin
                                if (w_acc_raw < w_min || w_acc_raw > CP_MAX ||
                                    (w_acc_raw >= HI_MIN && w_acc_raw <= LO_MAX)) begin
                                    n_phase = PH_IDLE;
                                    w_res   = fail_res(ERR_NON_CANON);
                                end else begin
                                    w_emit  = 1'b1;
                                    w_cp    = w_acc_raw;
                                    n_phase = PH_TEXT;
                                end
                            end
                        end
                    end
                    PH_IDLE, PH_TEXT: begin
                        n_phase = PH_TEXT;
                        if (i_text_byte == CH_QUOTE) begin
                            n_phase      = PH_IDLE;
                            w_res        = '0;
                            w_res.cnt    = 3'd1;
                            w_res.status = ST_QUOTE;
                            w_res.err    = ERR_NONE;
                        end else if (i_text_byte < 8'h20) begin
                            n_phase = PH_IDLE;
                            w_res   = fail_res(ERR_CTRL);
                        end else if (i_text_byte == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else if (i_text_byte < 8'h80) begin
                            w_emit = 1'b1;
                            w_cp   = {13'd0, i_text_byte};
                        end else if (i_text_byte >= 8'hc2 && i_text_byte <= 8'hdf) begin
                            n_acc   = {16'd0, i_text_byte[4:0]};
                            n_len   = 3'd2;
                            n_left  = 2'd1;
                            n_phase = PH_RAW;
                        end else if (i_text_byte >= 8'he0 && i_text_byte <= 8'hef) begin
                            n_acc   = {17'd0, i_text_byte[3:0]};
                            n_len   = 3'd3;
                            n_left  = 2'd2;
                            n_phase = PH_RAW;
                        end else if (i_text_byte >= 8'hf0 && i_text_byte <= 8'hf4) begin
                            n_acc   = {18'd0, i_text_byte[2:0]};
                            n_len   = 3'd4;
                            n_left  = 2'd3;
                            n_phase = PH_RAW;
                        end else begin
                            n_phase = PH_IDLE;
                            w_res   = fail_res(ERR_BAD_LEAD);
                        end
                    end
                endcase
            end
        end
        if (w_emit) begin
            w_res = encode_cp(w_cp);
        end
    end

    assign o_bundle = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hex_cnt <= '0;
            r_acc     <= '0;
            r_high    <= '0;
            r_left    <= '0;
            r_len     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_acc     <= n_acc;
            r_high    <= n_high;
            r_left    <= n_left;
            r_len     <= n_len;
        end
    end

endmodule

// File: rtl/core/jsu_emit.sv
`timescale 1ns / 1ps

module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_free,
    jsu_out_if.source        o_out
);
    import jsu_pkg::*;

    logic [2:0]              r_cnt;
    logic [RES_MAX-1:0][7:0] r_data;
    t_status                 r_status;
    t_err                    r_err;
    logic                    w_take;
    logic                    w_fill;

    assign w_take = (r_cnt != 3'd0) && o_out.ready;
    assign w_fill = i_load && (i_bundle.cnt != 3'd0);
    // Free when empty or when the final result of the held item leaves now.
    assign o_free = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_fill) begin
            r_cnt <= i_bundle.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_data   <= i_bundle.data;
            r_status <= i_bundle.status;
            r_err    <= i_bundle.err;
        end else if (w_take) begin
            r_data   <= r_data >> 8;
        end
    end

    assign o_out.valid        = (r_cnt != 3'd0);
    assign o_out.decoded_byte = r_data[0];
    assign o_out.status       = r_status;
    assign o_out.err_code     = r_err;
    assign o_out.last         = (r_cnt == 3'd1);

endmodule

// File: rtl/core/json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps

// JSON string body decoder. Feed the bytes after an opening quote on i_in,
// with string_start set on the first item of each string; text_ended marks
// the end of the available text and carries no byte. o_out gives decoded
// UTF-8 bytes (status 0), then either the closing quote (status 1) or one
// error (status 2 with err_code). last marks the final result of an item.
// After a quote or an error the decoder ignores items until the next start.
// Both channels use valid/ready; an item moves when both are high.
// The first result of an item passes the input register, then the result
// register; the item waits while the result register is not yet free.
// Throughput: one item per cycle while each item gives at most one result
// and the receiver is ready; an item with several results (up to four for
// a code point) holds the result register until all have left, so output
// bandwidth of one result per cycle is the limit. The input register
// still takes one more item during that time.
// Reset clears the decoder to idle and empties both registers. If the
// receiver stalls, the current result holds and i_in.ready drops once the
// input register is also full.
module json_string_unescape_utf8_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_text_byte;
    logic       r_string_start;
    logic       r_text_ended;
    logic       w_free;
    logic       w_adv;
    t_bundle    w_bundle;

    assign w_adv      = r_in_valid && w_free;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_text_byte    <= i_in.text_byte;
            r_string_start <= i_in.string_start;
            r_text_ended   <= i_in.text_ended;
        end
    end

    jsu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_adv),
        .i_text_byte    (r_text_byte),
        .i_string_start (r_string_start),
        .i_text_ended   (r_text_ended),
        .o_bundle       (w_bundle)
    );

    jsu_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_bundle (w_bundle),
        .o_free   (w_free),
        .o_out    (o_out)
    );

endmodule

// File: rtl/core/jsu_chk.sv
`timescale 1ns / 1ps

module jsu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_decoded_byte,
    input logic [1:0] i_status,
    input logic [3:0] i_err_code,
    input logic       i_last
);
    import jsu_pkg::*;

    logic w_in_accept;
    assign w_in_accept = i_in_valid && i_in_ready;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_decoded_byte, i_status, i_err_code, i_last}))
        else $error("stalled result changed");

    // An empty result register never blocks the input side.
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with no result pending");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_status == ST_BYTE && i_err_code == ERR_NONE) ||
            (i_status == ST_QUOTE && i_err_code == ERR_NONE &&
                i_decoded_byte == 8'd0 && i_last) ||
            (i_status == ST_ERROR && i_err_code != ERR_NONE &&
                i_decoded_byte == 8'd0 && i_last))
        else $error("inconsistent result fields");

    // Bytes of one code point leave without a gap.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid && i_status == ST_BYTE)
        else $error("gap inside a multi-byte result");

    // No error or quote appears without an item having entered before it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_accept, 2) || $past(i_in_valid, 1) ||
            $past(i_in_valid, 2))
        else $error("result without an item");

endmodule

bind json_string_unescape_utf8_core jsu_chk u_jsu_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_decoded_byte (o_out.decoded_byte),
    .i_status       (o_out.status),
    .i_err_code     (o_out.err_code),
    .i_last         (o_out.last)
);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import jsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 130;

    typedef enum logic [3:0] {
        DEC_IDLE,
        DEC_TEXT,
        DEC_ESC,
        DEC_HEX1,
        DEC_WANT_BS,
        DEC_WANT_U,
        DEC_HEX2,
        DEC_RAW
    } t_dec_phase;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        t_err       err;
        logic       last;
    } t_res;

    // One input item; typed rows carry their own result instead of the decoder's.
    typedef struct {
        logic [7:0] txt;
        bit         start;
        bit         ended;
        bit         typed;
        bit         typed_one;
        logic [7:0] t_data;
        t_status    t_st;
        t_err       t_code;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_utf8_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    t_stim      stim_q [$];
    t_res       byte_exp_q [$];
    t_res       step_res [$];

    t_dec_phase dec_phase = DEC_IDLE;
    logic [1:0] hex_cnt = '0;
    logic [20:0] cp_acc = '0;
    logic [9:0] hi_bits = '0;
    logic [1:0] u8_left = '0;
    logic [2:0] u8_len = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  stall_req = 1'b0;
    bit  in_taken = 1'b0;
    bit  first_pending = 1'b0;
    int  gen_cnt = 0;
    int  n_fail = 0;
    int  n_items = 0;
    int  n_strings = 0;
    int  n_results = 0;
    int  n_quotes = 0;
    int  n_errors = 0;
    int  idle_cycles = 0;
    logic [13:0] err_seen = '0;
    t_stim s_acc;
    t_res  r_exp;
    t_res  r_act;

    t_stim dir_rows [25] = '{
        // idle after reset: ignored
        '{8'h41, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, ST_ERROR, ERR_UNTERM},
        '{8'h22, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, ST_QUOTE, ERR_NONE},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR, ERR_CTRL},
        '{8'h41, 1'b1, 1'b0, 1'b1, 1'b1, 8'h41, ST_BYTE,  ERR_NONE},
        '{8'h7f, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h5c, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h6e, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        // surrogate pair \uD83d\uDE00, mixed case digits
        '{8'h5c, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h75, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h44, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h38, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h33, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h64, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h5c, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h75, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h44, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h45, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h30, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h30, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR, ERR_BAD_LEAD},
        '{8'hff, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR, ERR_BAD_LEAD},
        // overlong three-byte form of zero
        '{8'he0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE,  ERR_NONE},
        '{8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR, ERR_NON_CANON}
    };

    // ---------------- decoder prediction ----------------

    function automatic void put_res(logic [7:0] d, t_status st, t_err e);
        t_res r;
        if (step_res.size() >= RES_MAX) return;
        r.data   = d;
        r.status = st;
        r.err    = e;
        r.last   = 1'b0;
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void fail_res(t_err e);
        put_res(8'h00, ST_ERROR, e);
        dec_phase = DEC_IDLE;
    endfunction

    function automatic void emit_cp(logic [20:0] cp);
        if (cp <= 21'h7f) begin
            put_res(cp[7:0], ST_BYTE, ERR_NONE);
        end else if (cp <= 21'h7ff) begin
            put_res({3'b110, cp[10:6]}, ST_BYTE, ERR_NONE);
            put_res({2'b10, cp[5:0]}, ST_BYTE, ERR_NONE);
        end else if (cp <= 21'hffff) begin
            put_res({4'b1110, cp[15:12]}, ST_BYTE, ERR_NONE);
            put_res({2'b10, cp[11:6]}, ST_BYTE, ERR_NONE);
            put_res({2'b10, cp[5:0]}, ST_BYTE, ERR_NONE);
        end else begin
            put_res({5'b11110, cp[20:18]}, ST_BYTE, ERR_NONE);
            put_res({2'b10, cp[17:12]}, ST_BYTE, ERR_NONE);
            put_res({2'b10, cp[11:6]}, ST_BYTE, ERR_NONE);
            put_res({2'b10, cp[5:0]}, ST_BYTE, ERR_NONE);
        end
    endfunction

    function automatic int hex_digit_val(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        return -1;
    endfunction

    // Shift one digit into the quad; true once four digits are in.
    function automatic bit take_hex(logic [7:0] b);
        int d;
        d = hex_digit_val(b);
        if (d < 0) begin
            fail_res(ERR_NON_HEX);
            return 1'b0;
        end
        cp_acc = {cp_acc[16:0], 4'(d)};
        if (hex_cnt == 2'd3) begin
            hex_cnt = 2'd0;
            return 1'b1;
        end
        hex_cnt = hex_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void decode_item(logic [7:0] b, bit start, bit ended);
        t_err        e;
        logic [20:0] lim;
        step_res.delete();
        if (start) begin
            hex_cnt   = '0;
            cp_acc    = '0;
            hi_bits   = '0;
            u8_left   = '0;
            u8_len    = '0;
            dec_phase = DEC_TEXT;
        end
        if (dec_phase == DEC_IDLE) return;
        if (ended) begin
            case (dec_phase)
                DEC_ESC:               e = ERR_CUT_ESCAPE;
                DEC_HEX1, DEC_HEX2:    e = ERR_CUT_HEX;
                DEC_WANT_BS, DEC_WANT_U: e = ERR_LONE_HIGH;
                DEC_RAW:               e = ERR_CUT_UTF8;
                default:               e = ERR_UNTERM;
            endcase
            fail_res(e);
        end else begin
            case (dec_phase)
                DEC_ESC: begin
                    dec_phase = DEC_TEXT;
                    case (b)
                        8'h22, 8'h5c, 8'h2f: put_res(b, ST_BYTE, ERR_NONE);
                        8'h62: put_res(8'h08, ST_BYTE, ERR_NONE);
                        8'h66: put_res(8'h0c, ST_BYTE, ERR_NONE);
                        8'h6e: put_res(8'h0a, ST_BYTE, ERR_NONE);
                        8'h72: put_res(8'h0d, ST_BYTE, ERR_NONE);
                        8'h74: put_res(8'h09, ST_BYTE, ERR_NONE);
                        8'h75: begin
                            dec_phase = DEC_HEX1;
                            hex_cnt   = '0;
                            cp_acc    = '0;
                        end
                        default: fail_res(ERR_ESCAPE);
                    endcase
                end
                DEC_HEX1: begin
                    if (take_hex(b)) begin
                        if (cp_acc >= 21'hd800 && cp_acc <= 21'hdbff) begin
                            // low ten bits are the offset from the surrogate base
                            hi_bits   = cp_acc[9:0];
                            dec_phase = DEC_WANT_BS;
                        end else if (cp_acc >= 21'hdc00 && cp_acc <= 21'hdfff) begin
                            fail_res(ERR_LONE_LOW);
                        end else begin
                            emit_cp(cp_acc);
                            dec_phase = DEC_TEXT;
                        end
                    end
                end
                DEC_WANT_BS: begin
                    if (b == 8'h5c) dec_phase = DEC_WANT_U;
                    else fail_res(ERR_LONE_HIGH);
                end
                DEC_WANT_U: begin
                    if (b == 8'h75) begin
                        dec_phase = DEC_HEX2;
                        hex_cnt   = '0;
                        cp_acc    = '0;
                    end else begin
                        fail_res(ERR_LONE_HIGH);
                    end
                end
                DEC_HEX2: begin
                    if (take_hex(b)) begin
                        if (cp_acc < 21'hdc00 || cp_acc > 21'hdfff) begin
                            fail_res(ERR_BAD_LOW);
                        end else begin
                            emit_cp(21'h10000 + {1'b0, hi_bits, cp_acc[9:0]});
                            dec_phase = DEC_TEXT;
                        end
                    end
                end
                DEC_RAW: begin
                    if (b[7:6] != 2'b10) begin
                        fail_res(ERR_BAD_CONT);
                    end else begin
                        cp_acc  = {cp_acc[14:0], b[5:0]};
                        u8_left = u8_left - 2'd1;
                        if (u8_left == 2'd0) begin
                            lim = (u8_len == 3'd2) ? 21'h80 :
                                  (u8_len == 3'd3) ? 21'h800 : 21'h10000;
                            if (cp_acc < lim || cp_acc > 21'h10ffff ||
                                (cp_acc >= 21'hd800 && cp_acc <= 21'hdfff)) begin
                                fail_res(ERR_NON_CANON);
                            end else begin
                                emit_cp(cp_acc);
                                dec_phase = DEC_TEXT;
                            end
                        end
                    end
                end
                default: begin
                    dec_phase = DEC_TEXT;
                    if (b == 8'h22) begin
                        put_res(8'h00, ST_QUOTE, ERR_NONE);
                        dec_phase = DEC_IDLE;
                    end else if (b < 8'h20) begin
                        fail_res(ERR_CTRL);
                    end else if (b == 8'h5c) begin
                        dec_phase = DEC_ESC;
                    end else if (b < 8'h80) begin
                        put_res(b, ST_BYTE, ERR_NONE);
                    end else if (b >= 8'hc2 && b <= 8'hdf) begin
                        cp_acc = {16'd0, b[4:0]};
                        u8_len = 3'd2;
                        u8_left = 2'd1;
                        dec_phase = DEC_RAW;
                    end else if (b >= 8'he0 && b <= 8'hef) begin
                        cp_acc = {17'd0, b[3:0]};
                        u8_len = 3'd3;
                        u8_left = 2'd2;
                        dec_phase = DEC_RAW;
                    end else if (b >= 8'hf0 && b <= 8'hf4) begin
                        cp_acc = {18'd0, b[2:0]};
                        u8_len = 3'd4;
                        u8_left = 2'd3;
                        dec_phase = DEC_RAW;
                    end else begin
                        fail_res(ERR_BAD_LEAD);
                    end
                end
            endcase
        end
        if (step_res.size() > 0) begin
            step_res[step_res.size() - 1].last = 1'b1;
        end
    endfunction

    // ---------------- stimulus generation ----------------

    task automatic add_item(input logic [7:0] b, input bit ended);
        t_stim s;
        s = '{b, first_pending, ended, 1'b0, 1'b0, 8'h00, ST_BYTE, ERR_NONE};
        first_pending = 1'b0;
        stim_q.insert(stim_q.size(), s);
        gen_cnt++;
    endtask

    // Emit the top ndig nibbles of v as hex digits, letters in either case.
    task automatic add_hex(input logic [15:0] v, input int ndig);
        logic [3:0] nib;
        for (int k = 3; k > 3 - ndig; k--) begin
            nib = v[k*4 +: 4];
            if (nib < 4'd10) add_item(8'h30 + 8'(nib), 1'b0);
            else add_item(($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10, 1'b0);
        end
    endtask

    task automatic add_lead(input int len);
        case (len)
            2: add_item(8'($urandom_range(8'hc2, 8'hdf)), 1'b0);
            3: add_item(8'($urandom_range(8'he0, 8'hef)), 1'b0);
            default: add_item(8'($urandom_range(8'hf0, 8'hf4)), 1'b0);
        endcase
    endtask

    task automatic add_cont();
        add_item(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
    endtask

    task automatic add_high();
        add_item(8'h5c, 1'b0);
        add_item(8'h75, 1'b0);
        add_hex(16'hd800 + 16'($urandom_range(0, 16'h3ff)), 4);
    endtask

    task automatic gen_string();
        int          n_tok;
        int          len;
        int          n;
        logic [7:0]  c;
        logic [15:0] w;
        logic [20:0] cp;
        bit          broken;
        // stray item outside a string, or continuing an abandoned one
        if ($urandom_range(9) == 0) add_item(8'($urandom), 1'b0);
        first_pending = 1'b1;
        broken = 1'b0;
        n_tok = $urandom_range(0, 6);
        for (int i = 0; i < n_tok && !broken; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    c = 8'($urandom_range(8'h20, 8'h7e));
                    if (c == 8'h22 || c == 8'h5c) c = 8'h7e;
                    add_item(c, 1'b0);
                end
                6, 7: begin
                    add_item(8'h5c, 1'b0);
                    case ($urandom_range(0, 7))
                        0: add_item(8'h22, 1'b0);
                        1: add_item(8'h5c, 1'b0);
                        2: add_item(8'h2f, 1'b0);
                        3: add_item(8'h62, 1'b0);
                        4: add_item(8'h66, 1'b0);
                        5: add_item(8'h6e, 1'b0);
                        6: add_item(8'h72, 1'b0);
                        default: add_item(8'h74, 1'b0);
                    endcase
                end
                8, 9: begin
                    case ($urandom_range(0, 2))
                        0: w = 16'($urandom_range(0, 16'h7f));
                        1: w = 16'($urandom_range(16'h80, 16'h7ff));
                        default: w = 16'($urandom_range(16'h800, 16'hffff));
                    endcase
                    if (w >= 16'hd800 && w <= 16'hdfff) w = w ^ 16'h4000;
                    add_item(8'h5c, 1'b0);
                    add_item(8'h75, 1'b0);
                    add_hex(w, 4);
                end
                10, 11: begin
                    add_high();
                    add_item(8'h5c, 1'b0);
                    add_item(8'h75, 1'b0);
                    add_hex(16'hdc00 + 16'($urandom_range(0, 16'h3ff)), 4);
                end
                12, 13, 14: begin
                    case ($urandom_range(0, 2))
                        0: begin
                            cp = 21'($urandom_range(21'h80, 21'h7ff));
                            add_item({3'b110, cp[10:6]}, 1'b0);
                        end
                        1: begin
                            cp = 21'($urandom_range(21'h800, 21'hffff));
                            if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h4000;
                            add_item({4'b1110, cp[15:12]}, 1'b0);
                            add_item({2'b10, cp[11:6]}, 1'b0);
                        end
                        default: begin
                            cp = 21'($urandom_range(21'h10000, 21'h10ffff));
                            add_item({5'b11110, cp[20:18]}, 1'b0);
                            add_item({2'b10, cp[17:12]}, 1'b0);
                            add_item({2'b10, cp[11:6]}, 1'b0);
                        end
                    endcase
                    add_item({2'b10, cp[5:0]}, 1'b0);
                end
                default: begin
                    broken = 1'b1;
                    case ($urandom_range(0, 11))
                        0: begin
                            c = 8'($urandom);
                            case (c)
                                8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74,
                                8'h75: c = 8'h78;
                                default: ;
                            endcase
                            add_item(8'h5c, 1'b0);
                            add_item(c, 1'b0);
                        end
                        1: begin
                            add_item(8'h5c, 1'b0);
                            add_item(8'h75, 1'b0);
                            add_hex(16'($urandom), $urandom_range(0, 3));
                            c = 8'($urandom);
                            if (hex_digit_val(c) >= 0) c = 8'h67;
                            add_item(c, 1'b0);
                        end
                        2: begin
                            add_item(8'h5c, 1'b0);
                            add_item(8'h75, 1'b0);
                            add_hex(16'hdc00 + 16'($urandom_range(0, 16'h3ff)), 4);
                        end
                        3: begin
                            add_high();
                            c = 8'($urandom);
                            if (c == 8'h5c) c = 8'h41;
                            add_item(c, 1'b0);
                        end
                        4: begin
                            add_high();
                            add_item(8'h5c, 1'b0);
                            c = 8'($urandom);
                            if (c == 8'h75) c = 8'h41;
                            add_item(c, 1'b0);
                        end
                        5: begin
                            add_high();
                            add_item(8'h5c, 1'b0);
                            add_item(8'h75, 1'b0);
                            w = 16'($urandom);
                            if (w >= 16'hdc00 && w <= 16'hdfff) w = w ^ 16'h4000;
                            add_hex(w, 4);
                        end
                        6: begin
                            if ($urandom_range(1)) add_item(8'($urandom_range(8'h80, 8'hc1)), 1'b0);
                            else add_item(8'($urandom_range(8'hf5, 8'hff)), 1'b0);
                        end
                        7: begin
                            len = $urandom_range(2, 4);
                            add_lead(len);
                            n = $urandom_range(0, len - 2);
                            repeat (n) add_cont();
                            c = 8'($urandom);
                            if (c[7:6] == 2'b10) c[6] = 1'b1;
                            add_item(c, 1'b0);
                        end
                        8: begin
                            if ($urandom_range(1)) begin
                                add_item(8'he0, 1'b0);
                                add_item(8'($urandom_range(8'h80, 8'h9f)), 1'b0);
                            end else begin
                                add_item(8'hf0, 1'b0);
                                add_item(8'($urandom_range(8'h80, 8'h8f)), 1'b0);
                                add_cont();
                            end
                            add_cont();
                        end
                        9: begin
                            add_item(8'hed, 1'b0);
                            add_item(8'($urandom_range(8'ha0, 8'hbf)), 1'b0);
                            add_cont();
                        end
                        10: begin
                            add_item(8'hf4, 1'b0);
                            add_item(8'($urandom_range(8'h90, 8'hbf)), 1'b0);
                            add_cont();
                            add_cont();
                        end
                        default: add_item(8'($urandom_range(0, 8'h1f)), 1'b0);
                    endcase
                end
            endcase
        end
        n = $urandom_range(0, 19);
        if (broken || n < 14) begin
            add_item(8'h22, 1'b0);
        end else begin
            // cut the text in plain text or partway through an escape, a quad, a surrogate pair or a raw sequence
            case ($urandom_range(0, 4))
                0: ;
                1: add_item(8'h5c, 1'b0);
                2: begin
                    add_item(8'h5c, 1'b0);
                    add_item(8'h75, 1'b0);
                    add_hex(16'($urandom), $urandom_range(0, 3));
                end
                3: begin
                    add_high();
                    case ($urandom_range(0, 2))
                        0: ;
                        1: add_item(8'h5c, 1'b0);
                        default: begin
                            add_item(8'h5c, 1'b0);
                            add_item(8'h75, 1'b0);
                            add_hex(16'($urandom), $urandom_range(0, 3));
                        end
                    endcase
                end
                default: begin
                    len = $urandom_range(2, 4);
                    add_lead(len);
                    n = $urandom_range(0, len - 2);
                    repeat (n) add_cont();
                end
            endcase
            // otherwise abandon the string; the next start clears it
            if ($urandom_range(1)) add_item(8'($urandom), 1'b1);
        end
    endtask

    task automatic gen_phase(input int target);
        gen_cnt = 0;
        while (gen_cnt < target) gen_string();
    endtask

    // ---------------- drivers ----------------

    initial begin
        in_if.valid        = 1'b0;
        in_if.text_byte    = 8'h00;
        in_if.string_start = 1'b0;
        in_if.text_ended   = 1'b0;
        forever begin
            @(negedge i_clk);
            // hold an offered item until it is taken
            if (!(in_if.valid && !in_taken)) begin
                if (i_rst_n && stim_q.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid        <= 1'b1;
                    in_if.text_byte    <= stim_q[0].txt;
                    in_if.string_start <= stim_q[0].start;
                    in_if.text_ended   <= stim_q[0].ended;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                out_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
            end
            out_if.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            // check results first so an item taken at this edge cannot match
            if (out_if.valid && out_if.ready) begin
                n_results++;
                r_act = '{out_if.decoded_byte, t_status'(out_if.status),
                          t_err'(out_if.err_code), out_if.last};
                if (out_if.status == ST_QUOTE) n_quotes++;
                if (out_if.status == ST_ERROR) begin
                    n_errors++;
                    if (out_if.err_code < 4'd14) err_seen[out_if.err_code] = 1'b1;
                end
                if (byte_exp_q.size() == 0) begin
                    $display("%0t: unexpected result data %02h status %0d err %0d last %0d",
                             $time, r_act.data, r_act.status, r_act.err, r_act.last);
                    n_fail++;
                end else begin
                    r_exp = byte_exp_q.pop_front();
                    if (r_act.data !== r_exp.data || r_act.status !== r_exp.status ||
                        r_act.err !== r_exp.err || r_act.last !== r_exp.last) begin
                        $display("%0t: mismatch exp data %02h status %0d err %0d last %0d",
                                 $time, r_exp.data, r_exp.status, r_exp.err, r_exp.last);
                        $display("%0t:          got data %02h status %0d err %0d last %0d",
                                 $time, r_act.data, r_act.status, r_act.err, r_act.last);
                        n_fail++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                s_acc = stim_q.pop_front();
                n_items++;
                if (in_if.string_start) n_strings++;
                decode_item(in_if.text_byte, in_if.string_start, in_if.text_ended);
                if (s_acc.typed) begin
                    if (s_acc.typed_one)
                        byte_exp_q.insert(byte_exp_q.size(),
                            t_res'{s_acc.t_data, s_acc.t_st, s_acc.t_code, 1'b1});
                end else begin
                    foreach (step_res[k]) byte_exp_q.insert(byte_exp_q.size(), step_res[k]);
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[json_string_unescape_utf8_core] ERROR");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 53;
        foreach (dir_rows[k]) stim_q.insert(stim_q.size(), dir_rows[k]);
        gen_phase(PHASE_ITEMS);
        while (stim_q.size() > 0) @(negedge i_clk);

        send_idle_pct = 53;
        recv_idle_pct = 33;
        gen_phase(PHASE_ITEMS);
        while (stim_q.size() > 0) @(negedge i_clk);

        // full rate, with one long output stall to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_phase(PHASE_ITEMS);
        stall_req = 1'b1;
        while (stim_q.size() > 0 || byte_exp_q.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d items in %0d strings; %0d results checked (%0d quotes, %0d errors)",
                 n_items, n_strings, n_results, n_quotes, n_errors);
        $display("Error codes reported (bit per code): %014b", err_seen);
        if (n_fail == 0) begin
            $display("[json_string_unescape_utf8_core] OK");
        end else begin
            $display("[json_string_unescape_utf8_core] ERROR");
        end
        $finish;
    end

endmodule
